// ----- rtl/iee_pkg.sv -----
// Shared types and constants for the infix expression evaluator.
// Depends on nothing; the datapath, controller, top level and checker import it.
`default_nettype none

package iee_pkg;

  // Character codes that the parser reacts to
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_CR    = 8'h0D;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_EDGE    = 3'd3;
  localparam logic [2:0] ST_CONSEC  = 3'd4;
  localparam logic [2:0] ST_DIVZERO = 3'd5;

  localparam int OUT_W = 32;

  // Class of the character held in the datapath
  typedef enum logic [1:0] {
    CH_WS,
    CH_DIGIT,
    CH_OP,
    CH_BAD
  } char_cls_t;

  // Class of the last character that was not white space
  typedef enum logic [1:0] {
    PC_NONE  = 2'd0,
    PC_DIGIT = 2'd1,
    PC_OP    = 2'd2,
    PC_BAD   = 2'd3
  } prev_cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_END,
    S_CLOSE,
    S_ARITH,
    S_APPLY,
    S_FINISH
  } ctl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_char;
    logic digit;
    logic bad;
    logic op_mark;
    logic num_copy;
    logic div_zero;
    logic unit_start;
    logic unit_take;
    logic apply_op;
    logic apply_end;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    char_cls_t cls;
    logic      last;
    prev_cls_t prev;
    logic      term_started;
    logic      op_is_div;
    logic      cur_zero;
    logic      unit_done;
    logic      out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/iee_stream_if.sv -----
// Valid/ready channel interfaces for the evaluator's input and result words.
// Depends on nothing.
`default_nettype none

interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [2:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/iee_muldiv.sv -----
// Shared iterative multiplier and signed divider, one bit per cycle.
// Depends on nothing but its parameter.
`default_nettype none

module iee_muldiv #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic         is_div,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [W-1:0]      result
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  sh_r, sh_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;

  // Step the shift-add or restoring-divide iteration
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    b_nxt    = b_r;
    mag_a    = a[W-1] ? (~a + 1'b1) : a;
    mag_b    = b[W-1] ? (~b + 1'b1) : b;
    rem_sh   = {acc_r, sh_r[W-1]};
    diff     = rem_sh - {1'b0, b_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      div_nxt  = is_div;
      neg_nxt  = a[W-1] ^ b[W-1];
      acc_nxt  = '0;
      sh_nxt   = is_div ? mag_a : b;
      b_nxt    = is_div ? mag_b : a;
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[W]) begin
          acc_nxt = diff[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh[W-1:0];
          sh_nxt  = {sh_r[W-2:0], 1'b0};
        end
      end else begin
        if (sh_r[0]) begin
          acc_nxt = acc_r + b_r;
        end
        b_nxt  = {b_r[W-2:0], 1'b0};
        sh_nxt = {1'b0, sh_r[W-1:1]};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    b_r   <= b_nxt;
  end

  assign done   = done_r;
  assign result = div_r ? (neg_r ? (~sh_r + 1'b1) : sh_r) : acc_r;

endmodule

`default_nettype wire

// ----- rtl/iee_datapath.sv -----
// Evaluator datapath: number, term and sum registers, error tracking and
// the result word register. Depends on iee_pkg and iee_muldiv.
`default_nettype none

module iee_datapath #(
  parameter int W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iee_pkg::dp_cmd_t   cmd,
  output iee_pkg::dp_stat_t       stat,
  input  wire logic [7:0]         char_code,
  input  wire logic               last_char,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_value,
  output logic        [2:0]       out_status
);

  import iee_pkg::*;

  logic [7:0]   char_r;
  logic         last_r;
  logic [W-1:0] cur_r, cur_nxt;
  logic [W-1:0] prod_r, prod_nxt;
  logic [W-1:0] sum_r, sum_nxt;
  logic         op_div_r, op_div_nxt;
  logic         started_r, started_nxt;
  logic         add_neg_r, add_neg_nxt;
  prev_cls_t    prev_r, prev_nxt;
  logic         first_op_r, first_op_nxt;
  logic [2:0]   err_r, err_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic signed [31:0] oval_r;
  logic [2:0]   ostat_r;

  char_cls_t    cls;
  logic         is_mul_div;
  logic [W-1:0] digit_val;
  logic [W-1:0] term_sum;
  logic [W-1:0] unit_res;
  logic         unit_done;
  logic [2:0]   fin_status;
  logic signed [31:0] fin_value;

  // Keep the lowest nonzero error code
  function automatic logic [2:0] note_err(input logic [2:0] cur, input logic [2:0] code);
    note_err = (cur == ST_OK || code < cur) ? code : cur;
  endfunction

  iee_muldiv #(.W(W)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.unit_start),
    .is_div (op_div_r),
    .a      (prod_r),
    .b      (cur_r),
    .done   (unit_done),
    .result (unit_res)
  );

  // Classify the held character
  always_comb begin
    if (char_r inside {[CHR_TAB:CHR_CR], CHR_SPACE}) begin
      cls = CH_WS;
    end else if (char_r inside {[CHR_ZERO:CHR_NINE]}) begin
      cls = CH_DIGIT;
    end else if (char_r inside {CHR_PLUS, CHR_MINUS, CHR_STAR, CHR_SLASH}) begin
      cls = CH_OP;
    end else begin
      cls = CH_BAD;
    end
  end

  assign is_mul_div = (char_r == CHR_STAR) || (char_r == CHR_SLASH);
  assign digit_val  = W'(char_r[3:0]);
  assign term_sum   = add_neg_r ? (sum_r - prod_r) : (sum_r + prod_r);

  // Work out the status and value of a finished expression
  always_comb begin
    if (prev_r == PC_NONE) begin
      fin_status = ST_EMPTY;
    end else begin
      fin_status = err_r;
      if ((first_op_r || prev_r == PC_OP) && (err_r == ST_OK || err_r > ST_EDGE)) begin
        fin_status = ST_EDGE;
      end
    end
    fin_value = (fin_status == ST_OK) ? OUT_W'(signed'(sum_r)) : '0;
  end

  // Apply the controller's commands to the evaluation state
  always_comb begin
    cur_nxt      = cur_r;
    prod_nxt     = prod_r;
    sum_nxt      = sum_r;
    op_div_nxt   = op_div_r;
    started_nxt  = started_r;
    add_neg_nxt  = add_neg_r;
    prev_nxt     = prev_r;
    first_op_nxt = first_op_r;
    err_nxt      = err_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    if (cmd.digit) begin
      cur_nxt  = {cur_r[W-4:0], 3'b000} + {cur_r[W-2:0], 1'b0} + digit_val;
      prev_nxt = PC_DIGIT;
    end
    if (cmd.bad) begin
      err_nxt  = note_err(err_r, ST_INVALID);
      prev_nxt = PC_BAD;
    end
    if (cmd.op_mark) begin
      if (prev_r == PC_NONE) begin
        first_op_nxt = 1'b1;
      end
      if (prev_r == PC_OP) begin
        err_nxt = note_err(err_r, ST_CONSEC);
      end
    end
    if (cmd.num_copy) begin
      prod_nxt = cur_r;
    end
    if (cmd.div_zero) begin
      err_nxt = note_err(err_r, ST_DIVZERO);
    end
    if (cmd.unit_take) begin
      prod_nxt = unit_res;
    end
    if (cmd.apply_op) begin
      cur_nxt  = '0;
      prev_nxt = PC_OP;
      if (is_mul_div) begin
        started_nxt = 1'b1;
        op_div_nxt  = (char_r == CHR_SLASH);
      end else begin
        sum_nxt     = term_sum;
        started_nxt = 1'b0;
        add_neg_nxt = (char_r == CHR_MINUS);
      end
    end
    if (cmd.apply_end) begin
      cur_nxt     = '0;
      sum_nxt     = term_sum;
      started_nxt = 1'b0;
    end
    if (cmd.finish) begin
      ovalid_nxt   = 1'b1;
      cur_nxt      = '0;
      prod_nxt     = '0;
      sum_nxt      = '0;
      op_div_nxt   = 1'b0;
      started_nxt  = 1'b0;
      add_neg_nxt  = 1'b0;
      prev_nxt     = PC_NONE;
      first_op_nxt = 1'b0;
      err_nxt      = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      prod_r     <= '0;
      sum_r      <= '0;
      op_div_r   <= 1'b0;
      started_r  <= 1'b0;
      add_neg_r  <= 1'b0;
      prev_r     <= PC_NONE;
      first_op_r <= 1'b0;
      err_r      <= ST_OK;
      ovalid_r   <= 1'b0;
    end else begin
      cur_r      <= cur_nxt;
      prod_r     <= prod_nxt;
      sum_r      <= sum_nxt;
      op_div_r   <= op_div_nxt;
      started_r  <= started_nxt;
      add_neg_r  <= add_neg_nxt;
      prev_r     <= prev_nxt;
      first_op_r <= first_op_nxt;
      err_r      <= err_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // Hold the input word and the result word
  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_r <= char_code;
      last_r <= last_char;
    end
    if (cmd.finish) begin
      oval_r  <= fin_value;
      ostat_r <= fin_status;
    end
  end

  assign stat.cls          = cls;
  assign stat.last         = last_r;
  assign stat.prev         = prev_r;
  assign stat.term_started = started_r;
  assign stat.op_is_div    = op_div_r;
  assign stat.cur_zero     = (cur_r == '0);
  assign stat.unit_done    = unit_done;
  assign stat.out_free     = !ovalid_r || out_ready;

  assign out_valid  = ovalid_r;
  assign out_value  = oval_r;
  assign out_status = ostat_r;

endmodule

`default_nettype wire

// ----- rtl/iee_controller.sv -----
// Evaluator sequencer: walks each input word through decode and, for an operator
// or the end, through number close, arithmetic and term update. Depends on iee_pkg.
`default_nettype none

module iee_controller (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire iee_pkg::dp_stat_t stat,
  output iee_pkg::dp_cmd_t       cmd
);

  import iee_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       ending_r, ending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ending_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ending_r <= ending_nxt;
    end
  end

  // Pick the next state and drive the datapath commands
  always_comb begin
    state_nxt  = state_r;
    ending_nxt = ending_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_char = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = stat.last ? S_END : S_IDLE;
        case (stat.cls)
          CH_DIGIT: cmd.digit = 1'b1;
          CH_BAD:   cmd.bad   = 1'b1;
          CH_OP: begin
            cmd.op_mark = 1'b1;
            ending_nxt  = 1'b0;
            state_nxt   = S_CLOSE;
          end
          default: ;
        endcase
      end
      // A trailing number still has to be folded in
      S_END: begin
        if (stat.prev == PC_DIGIT) begin
          ending_nxt = 1'b1;
          state_nxt  = S_CLOSE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CLOSE: begin
        if (!stat.term_started) begin
          cmd.num_copy = 1'b1;
          state_nxt    = S_APPLY;
        end else if (stat.op_is_div && stat.cur_zero) begin
          cmd.div_zero = 1'b1;
          state_nxt    = S_APPLY;
        end else begin
          cmd.unit_start = 1'b1;
          state_nxt      = S_ARITH;
        end
      end
      S_ARITH: begin
        if (stat.unit_done) begin
          cmd.unit_take = 1'b1;
          state_nxt     = S_APPLY;
        end
      end
      S_APPLY: begin
        if (ending_r) begin
          cmd.apply_end = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          cmd.apply_op = 1'b1;
          state_nxt    = stat.last ? S_FINISH : S_IDLE;
        end
      end
      // Wait for room in the result register
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/infix_integer_expression_evaluator_core.sv -----
// Infix integer expression evaluator, top level.
// Depends on iee_pkg, iee_stream_if, iee_controller and iee_datapath.
//
// Usage: send an expression one character per word on in_ch (valid/ready),
// with last_char set on the final character. Decimal integers and + - * /
// are understood, white space is skipped, * and / bind tighter than + and -,
// division truncates towards zero and all arithmetic wraps at VALUE_WIDTH.
// One word per expression comes out on out_ch: a signed 32-bit value and a
// status code (0 on success; on any error the value is 0).
// A digit, white space or invalid character is accepted and decoded.
// An operator then also closes the pending number and updates the sum
// or term, waiting on the bit-serial multiply/divide unit when it closes
// a product or quotient. The final word also folds in a trailing number
// and loads the result register together with its valid flag.
// Stalls: the result sits in an output register, so characters of the next
// expression are taken while it waits; only the next result waits for it.
// Reset (synchronous, rst_n low) clears all evaluation state and drops any
// pending result.
`default_nettype none

module infix_integer_expression_evaluator_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  iee_in_if.sink     in_ch,
  iee_out_if.source  out_ch
);

  import iee_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iee_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iee_datapath #(.W(VALUE_WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .char_code  (in_ch.char_code),
    .last_char  (in_ch.last_char),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.value),
    .out_status (out_ch.status)
  );

endmodule

`default_nettype wire

// ----- rtl/iee_checker.sv -----
// Port-level checks for the evaluator and the bind that attaches them.
// Depends on iee_pkg and infix_integer_expression_evaluator_core.
`default_nettype none

module iee_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [31:0] out_value,
  input wire logic        [2:0]  out_status
);

  import iee_pkg::*;

  // Drop any result word at reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // Status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DIVZERO)
    else $error("undefined status code");

  // Any error reports a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_value == 32'sd0)
    else $error("nonzero value with error status");

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_status)))
    else $error("stalled result word changed");

endmodule

bind infix_integer_expression_evaluator_core iee_checker u_iee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);

`default_nettype wire
